// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the claim/complete controller RTL.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// prop must hold at every clock edge out of reset
`define PCC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// cond must never be true out of reset
`define PCC_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define PCC_ASSERT(lbl, prop, msg)
`define PCC_NEVER(lbl, cond, msg)
`endif
`endif

// ===== hdl/plic_cc_pkg.sv =====
// Types, codes and constants of the interrupt claim/complete controller.
// No dependencies.
`default_nettype none

package plic_cc_pkg;

  // word offsets (byte address >> 2)
  localparam logic [23:0] PEND_WORD   = 24'h000400;
  localparam logic [23:0] ENABLE_BASE = 24'h000800;
  localparam logic [23:0] CTX_BASE    = 24'h080000;
  localparam logic [9:0]  SUB_THRESH  = 10'h000;
  localparam logic [9:0]  SUB_CLAIM   = 10'h001;
  localparam logic [31:0] ENABLE_MASK = ~32'h1;
  localparam int unsigned CTX_FW      = 5;  // room for up to 32 contexts

  typedef enum logic [1:0] {
    REQ_UPDATE = 2'd0,
    REQ_READ   = 2'd1,
    REQ_WRITE  = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    WID_BYTE    = 2'd0,
    WID_HALF    = 2'd1,
    WID_WORD    = 2'd2,
    WID_ILLEGAL = 2'd3
  } width_t;

  typedef enum logic [1:0] {
    FLT_NONE     = 2'd0,
    FLT_ACCESS   = 2'd1,
    FLT_MISALIGN = 2'd2,
    FLT_WIDTH    = 2'd3
  } fault_t;

  typedef enum logic [3:0] {
    OP_NOP      = 4'd0,
    OP_UPDATE   = 4'd1,
    OP_RD_PRIO  = 4'd2,
    OP_RD_PEND  = 4'd3,
    OP_RD_EN    = 4'd4,
    OP_WR_EN    = 4'd5,
    OP_RD_THR   = 4'd6,
    OP_RD_CLAIM = 4'd7,
    OP_WR_DONE  = 4'd8
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [CTX_FW-1:0] ctx;
    fault_t            fault;
  } dec_t;

  // index of the highest set bit, 0 for an empty word
  function automatic logic [4:0] top_bit(input logic [31:0] v);
    logic [4:0] n;
    n = '0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) n = 5'(i);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/plic_claim_complete_controller.sv =====
// Top level of the interrupt claim/complete controller.
// Depends on plic_cc_pkg, plic_cc_decode, plic_cc_state and assert_macros.svh.
//
// Usage:
//  - Input channel (in_valid/in_ready): one beat is either an update of the 32
//    source levels or a word bus access (read or write) at in_address.
//  - Result channel (out_valid/out_ready): exactly one beat per input beat, in
//    order: read data, fault code and the per-hart external irq lines as they
//    stand after that beat's effect.
//  - Timing: the input register loads on the input accept edge; decode/claim
//    logic then fills the result register, which raises out_valid and holds the
//    result beat until it is taken.
//  - Throughput: one beat per cycle with out_ready high; the limit is the single
//    pass through decode, priority encoder and state update between two registers.
//  - Stall: while out_ready is low with a result held, the beat in the input
//    register waits and in_ready drops; the input register still takes one
//    beat while the result register is full.
//  - Reset (rst_n low, synchronous): pending, in-flight and enable bits clear,
//    both registers empty, no result shown.
`default_nettype none

`include "assert_macros.svh"

module plic_claim_complete_controller #(
  parameter int NUM_HARTS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [31:0] in_active_sources,
  input  logic [25:0] in_address,
  input  logic [1:0]  in_access_width,
  input  logic [31:0] in_write_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_read_data,
  output logic [1:0]  out_fault_code,
  output logic [3:0]  out_ext_irq_lines
);
  import plic_cc_pkg::*;

  // input register
  logic        in_vld_r;
  logic [1:0]  req_r;
  logic [31:0] active_r;
  logic [25:0] addr_r;
  logic [1:0]  width_r;
  logic [31:0] wdata_r;

  // result register
  logic        out_vld_r;
  logic [31:0] rdata_r;
  logic [1:0]  fault_r;
  logic [3:0]  irq_r;

  logic        adv;       // beat in input register moves to result register
  logic        in_fire;
  dec_t        dec;
  logic [31:0] rdata;
  logic [3:0]  irq;

  assign adv      = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || adv;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r    <= in_req_type;
      active_r <= in_active_sources;
      addr_r   <= in_address;
      width_r  <= in_access_width;
      wdata_r  <= in_write_data;
    end
  end

  plic_cc_decode #(
    .NUM_HARTS(NUM_HARTS)
  ) u_decode (
    .req_type    (req_r),
    .address     (addr_r),
    .access_width(width_r),
    .dec         (dec)
  );

  plic_cc_state #(
    .NUM_HARTS(NUM_HARTS)
  ) u_state (
    .clk           (clk),
    .rst_n         (rst_n),
    .go            (adv),
    .dec           (dec),
    .active_sources(active_r),
    .write_data    (wdata_r),
    .read_data     (rdata),
    .ext_irq_lines (irq)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  // faulted accesses return zero data; ops that read nothing leave rdata zero
  always_ff @(posedge clk) begin
    if (adv) begin
      rdata_r <= rdata;
      fault_r <= dec.fault;
      irq_r   <= irq;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_read_data     = rdata_r;
  assign out_fault_code    = fault_r;
  assign out_ext_irq_lines = irq_r;

  `PCC_ASSERT(a_ready_when_empty, !out_vld_r |-> in_ready, "input stalled with empty output")
  `PCC_ASSERT(a_adv_loads, adv |=> out_vld_r, "result lost on advance")
  `PCC_NEVER(a_fault_zero, out_vld_r && fault_r != FLT_NONE && rdata_r != '0, "faulted beat carries data")

endmodule

`default_nettype wire

// ===== hdl/plic_cc_decode.sv =====
// Request and address decode: turns one beat into an operation, context and fault.
// Depends on plic_cc_pkg.
`default_nettype none

module plic_cc_decode #(
  parameter int NUM_HARTS = 4
) (
  input  logic [1:0]        req_type,
  input  logic [25:0]       address,
  input  logic [1:0]        access_width,
  output plic_cc_pkg::dec_t dec
);
  import plic_cc_pkg::*;

  localparam logic [13:0] NH = 14'(NUM_HARTS);

  logic [23:0] w;
  logic [13:0] en_ctx;
  logic [13:0] cx_ctx;
  logic        is_wr;
  logic        prio_hit;
  logic        pend_hit;
  logic        en_hit;
  logic        cx_rgn;
  logic        thr_hit;
  logic        clm_hit;

  assign w        = address[25:2];
  assign en_ctx   = w[18:5] - ENABLE_BASE[18:5];
  assign cx_ctx   = w[23:10] - CTX_BASE[23:10];
  assign is_wr    = (req_t'(req_type) == REQ_WRITE);
  assign prio_hit = (w[23:5] == '0) && (w[4:0] != '0);
  assign pend_hit = (w == PEND_WORD);
  assign en_hit   = (w >= ENABLE_BASE) && (w < CTX_BASE) && (w[4:0] == '0) && (en_ctx < NH);
  assign cx_rgn   = (w >= CTX_BASE) && (cx_ctx < NH);
  assign thr_hit  = cx_rgn && (w[9:0] == SUB_THRESH);
  assign clm_hit  = cx_rgn && (w[9:0] == SUB_CLAIM);

  always_comb begin
    dec.op    = OP_NOP;
    dec.ctx   = '0;
    dec.fault = FLT_NONE;
    case (req_t'(req_type))
      REQ_UPDATE: dec.op = OP_UPDATE;
      REQ_READ, REQ_WRITE: begin
        case (width_t'(access_width))
          WID_WORD: begin
            if (prio_hit) begin
              dec.op = is_wr ? OP_NOP : OP_RD_PRIO;
            end else if (pend_hit) begin
              if (is_wr) dec.fault = FLT_ACCESS;
              else dec.op = OP_RD_PEND;
            end else if (en_hit) begin
              dec.ctx = en_ctx[CTX_FW-1:0];
              dec.op  = is_wr ? OP_WR_EN : OP_RD_EN;
            end else if (thr_hit) begin
              dec.op = is_wr ? OP_NOP : OP_RD_THR;
            end else if (clm_hit) begin
              dec.ctx = cx_ctx[CTX_FW-1:0];
              dec.op  = is_wr ? OP_WR_DONE : OP_RD_CLAIM;
            end else begin
              dec.fault = FLT_ACCESS;
            end
          end
          WID_ILLEGAL: dec.fault = FLT_WIDTH;
          default:     dec.fault = FLT_MISALIGN;
        endcase
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/plic_cc_state.sv =====
// Pending, in-flight and enable state with claim/complete logic and irq lines.
// Depends on plic_cc_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module plic_cc_state #(
  parameter int NUM_HARTS = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go,
  input  plic_cc_pkg::dec_t dec,
  input  logic [31:0]       active_sources,
  input  logic [31:0]       write_data,
  output logic [31:0]       read_data,
  output logic [3:0]        ext_irq_lines
);
  import plic_cc_pkg::*;

  localparam int IDX_W = (NUM_HARTS > 1) ? $clog2(NUM_HARTS) : 1;

  logic [31:0]      pend_r;
  logic [31:0]      pend_nxt;
  logic [31:0]      infl_r;
  logic [31:0]      infl_nxt;
  logic [31:0]      en_r   [NUM_HARTS];
  logic [31:0]      en_nxt [NUM_HARTS];
  logic [31:0]      en_sel;
  logic [31:0]      cand;
  logic [4:0]       src;
  logic             en_wr;
  logic [IDX_W-1:0] idx;

  assign idx    = dec.ctx[IDX_W-1:0];
  assign en_sel = en_r[idx];
  assign cand   = pend_r & en_sel;
  assign src    = top_bit(cand);

  always_comb begin
    pend_nxt  = pend_r;
    infl_nxt  = infl_r;
    read_data = '0;
    en_wr     = 1'b0;
    case (dec.op)
      OP_UPDATE: begin
        pend_nxt = pend_r | (active_sources & ~infl_r);
        infl_nxt = infl_r | active_sources;
      end
      OP_RD_PRIO: read_data = 32'd1;
      OP_RD_PEND: read_data = pend_r;
      OP_RD_EN:   read_data = en_sel;
      OP_WR_EN:   en_wr = 1'b1;
      OP_RD_CLAIM: begin
        if (cand != '0) begin
          read_data     = {27'd0, src};
          pend_nxt[src] = 1'b0;
        end
      end
      OP_WR_DONE: begin
        if ((write_data[31:5] == '0) && en_sel[write_data[4:0]]) begin
          infl_nxt[write_data[4:0]] = 1'b0;
        end
      end
      default: ;
    endcase
  end

  for (genvar h = 0; h < NUM_HARTS; h++) begin : g_en
    assign en_nxt[h] = (en_wr && (idx == IDX_W'(h))) ? (write_data & ENABLE_MASK) : en_r[h];
  end

  // lines reflect the state after this beat's effect
  for (genvar h = 0; h < 4; h++) begin : g_irq
    if (h < NUM_HARTS) begin : g_on
      assign ext_irq_lines[h] = |(pend_nxt & en_nxt[h]);
    end else begin : g_off
      assign ext_irq_lines[h] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      infl_r <= '0;
      for (int h = 0; h < NUM_HARTS; h++) en_r[h] <= '0;
    end else if (go) begin
      pend_r <= pend_nxt;
      infl_r <= infl_nxt;
      for (int h = 0; h < NUM_HARTS; h++) en_r[h] <= en_nxt[h];
    end
  end

  `PCC_ASSERT(a_state_hold, !go |=> ($stable(pend_r) && $stable(infl_r)), "state moved while idle")
  `PCC_ASSERT(a_upd_gate, (go && dec.op == OP_UPDATE) |=> ((pend_r & ~$past(pend_r) & $past(infl_r)) == '0), "pending set on in-flight source")
  `PCC_NEVER(a_claim_range, go && dec.op == OP_RD_CLAIM && read_data[31:5] != '0, "claim id out of range")

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for plic_claim_complete_controller.
// Drives update and bus beats with random gaps and output stalls, and checks
// every result against a cycle-free model of the controller held in this file.
// Depends on plic_cc_pkg and the controller RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import plic_cc_pkg::*;

  localparam int HARTS = 4;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned LONG_HOLD = 300;

  // expected content of one result beat
  typedef struct {
    logic [31:0] rdata;
    fault_t      fault;
    logic [3:0]  irq;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_req_type = REQ_NONE;
  logic [31:0] in_active_sources = '0;
  logic [25:0] in_address = '0;
  logic [1:0]  in_access_width = WID_WORD;
  logic [31:0] in_write_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_read_data;
  logic [1:0]  out_fault_code;
  logic [3:0]  out_ext_irq_lines;

  plic_claim_complete_controller #(
    .NUM_HARTS(HARTS)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_active_sources(in_active_sources),
    .in_address       (in_address),
    .in_access_width  (in_access_width),
    .in_write_data    (in_write_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_read_data    (out_read_data),
    .out_fault_code   (out_fault_code),
    .out_ext_irq_lines(out_ext_irq_lines)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the controller state. Reset value is all zero, which matches the
  // single reset at the start of the run.
  // ---------------------------------------------------------------------------
  logic [31:0] sh_pend = '0;               // latched pending sources
  logic [31:0] sh_busy = '0;               // sources claimed/in flight
  logic [31:0] sh_enable [HARTS] = '{default: '0};

  reply_t      resp_due [$];               // replies still owed by the DUT
  reply_t      last_reply;                 // reply predicted for the last beat sent
  reply_t      head_reply;
  int unsigned errors = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;

  // Applies one accepted beat to the shadow state and returns its reply.
  function automatic reply_t plic_beat_response(input req_t req, input logic [31:0] act,
                                                input logic [25:0] addr, input width_t wid,
                                                input logic [31:0] wd);
    reply_t      r;
    logic [23:0] w;
    logic [23:0] off;
    int unsigned c;
    logic [31:0] cand;
    logic        is_wr;
    logic        found;
    r.rdata = '0;
    r.fault = FLT_NONE;
    case (req)
      REQ_UPDATE: begin
        // sources still in flight do not re-latch
        sh_pend = sh_pend | (act & ~sh_busy);
        sh_busy = sh_busy | act;
      end
      REQ_READ, REQ_WRITE: begin
        if (wid == WID_WORD) begin
          w = addr[25:2];
          is_wr = (req == REQ_WRITE);
          if (w >= 24'd1 && w <= 24'd31) begin
            // priority words: fixed 1, writes dropped
            if (!is_wr) r.rdata = 32'd1;
          end else if (w == PEND_WORD) begin
            if (is_wr) r.fault = FLT_ACCESS;
            else r.rdata = sh_pend;
          end else if (w >= ENABLE_BASE && w < CTX_BASE) begin
            off = w - ENABLE_BASE;
            c = off >> 5;
            if (off[4:0] != 5'd0 || c >= HARTS) r.fault = FLT_ACCESS;
            else if (is_wr) sh_enable[c] = wd & ENABLE_MASK;
            else r.rdata = sh_enable[c];
          end else if (w >= CTX_BASE) begin
            off = w - CTX_BASE;
            c = off >> 10;
            if (c >= HARTS || off[9:0] > SUB_CLAIM) begin
              r.fault = FLT_ACCESS;
            end else if (off[9:0] == SUB_CLAIM) begin
              if (is_wr) begin
                // completion only frees a source the context has enabled
                if (wd <= 32'd31 && sh_enable[c][wd[4:0]]) sh_busy[wd[4:0]] = 1'b0;
              end else begin
                cand = sh_pend & sh_enable[c];
                found = 1'b0;
                for (int i = 31; i >= 0; i--) begin
                  if (!found && cand[i]) begin
                    found = 1'b1;
                    r.rdata = 32'(i);
                    sh_pend[i] = 1'b0;
                  end
                end
              end
            end
            // threshold word reads 0 and ignores writes
          end else begin
            r.fault = FLT_ACCESS;
          end
          if (is_wr) r.rdata = '0;
        end else if (wid == WID_ILLEGAL) begin
          r.fault = FLT_WIDTH;
        end else begin
          r.fault = FLT_MISALIGN;
        end
      end
      default: ;
    endcase
    for (int h = 0; h < 4; h++) begin
      r.irq[h] = (h < HARTS) ? |(sh_pend & sh_enable[h]) : 1'b0;
    end
    return r;
  endfunction

  // byte address of a context's enable word
  function automatic logic [25:0] enable_addr(input int unsigned c);
    return {ENABLE_BASE + 24'(c * 32), 2'b00};
  endfunction

  // byte address of a threshold (SUB_THRESH) or claim (SUB_CLAIM) word
  function automatic logic [25:0] ctx_addr(input int unsigned c, input logic [9:0] sub);
    return {CTX_BASE + 24'(c * 'h400) + 24'(sub), 2'b00};
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: bursts of back-to-back beats separated by random gaps. Called only
  // right after a rising edge; returns right after the accepting edge, with
  // in_valid still high so the next beat can follow without a bubble.
  // ---------------------------------------------------------------------------
  task automatic send_beat(input req_t req, input logic [31:0] act, input logic [25:0] addr,
                           input width_t wid, input logic [31:0] wd);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid          <= 1'b1;
    in_req_type       <= req;
    in_active_sources <= act;
    in_address        <= addr;
    in_access_width   <= wid;
    in_write_data     <= wd;
    do @(posedge clk); while (!in_ready);
    last_reply = plic_beat_response(req, act, addr, wid, wd);
    resp_due.push_back(last_reply);
  endtask

  // shorthands; unused fields get random values since the block ignores them
  task automatic word_read(input logic [25:0] addr);
    send_beat(REQ_READ, $urandom, addr, WID_WORD, $urandom);
  endtask

  task automatic word_write(input logic [25:0] addr, input logic [31:0] data);
    send_beat(REQ_WRITE, $urandom, addr, WID_WORD, data);
  endtask

  task automatic source_update(input logic [31:0] act);
    send_beat(REQ_UPDATE, act, 26'($urandom), width_t'($urandom_range(0, 3)), $urandom);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: out_ready follows runs of random length, some long always-ready
  // stretches, and a long hold-off whenever a test asks for one.
  // ---------------------------------------------------------------------------
  int unsigned hold_asks = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;
  int unsigned run_left = 0;

  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_served != hold_asks) begin
      hold_served <= hold_asks;
      hold_left   <= LONG_HOLD;
      out_ready   <= 1'b0;
    end else if (run_left != 0) begin
      run_left <= run_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_ready <= 1'b1;
      run_left  <= $urandom_range(20, 80);
    end else begin
      out_ready <= 1'($urandom_range(0, 1));
      run_left  <= $urandom_range(0, 5);
    end
  end

  // ---------------------------------------------------------------------------
  // Result check: every accepted result beat against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (resp_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat: read_data %h fault %0d irq %h", $time,
                 out_read_data, out_fault_code, out_ext_irq_lines);
      end else begin
        head_reply = resp_due.pop_front();
        if (out_read_data !== head_reply.rdata) begin
          errors++;
          $display("%0t: read_data expected %h actual %h", $time, head_reply.rdata,
                   out_read_data);
        end
        if (out_fault_code !== head_reply.fault) begin
          errors++;
          $display("%0t: fault_code expected %0d actual %0d", $time, head_reply.fault,
                   out_fault_code);
        end
        if (out_ext_irq_lines !== head_reply.irq) begin
          errors++;
          $display("%0t: ext_irq_lines expected %h actual %h", $time, head_reply.irq,
                   out_ext_irq_lines);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Walks the word map once: every region, every fault kind, odd requests.
  task automatic test_register_map();
    source_update(32'hFFFF_FFFF);                 // all sources pend and go in flight
    word_read(26'd4);                             // priority word 1
    word_read({24'd31, 2'b11});                   // priority word 31, low bits set
    word_write(26'd8, 32'hFFFF_FFFF);             // priority write is dropped
    word_read(26'd0);                             // word 0 is unmapped
    word_read({PEND_WORD, 2'b00});
    word_write({PEND_WORD, 2'b00}, 32'hFFFF_FFFF); // pending is read only
    word_write(enable_addr(0), 32'hFFFF_FFFF);    // bit 0 must read back clear
    word_read(enable_addr(0));
    word_write(enable_addr(3), 32'h8000_0001);
    word_read(enable_addr(3));
    word_read(enable_addr(HARTS));                // context past the last hart
    word_read(enable_addr(0) + 26'd4);            // inside the stride, not a word
    word_read(ctx_addr(0, SUB_THRESH));
    word_write(ctx_addr(0, SUB_THRESH), 32'hFFFF_FFFF);
    word_read(ctx_addr(0, SUB_CLAIM));            // claims source 31
    word_read(ctx_addr(3, SUB_CLAIM));            // 31 already taken: nothing left
    word_write(ctx_addr(0, SUB_CLAIM), 32'd31);   // complete 31
    word_write(ctx_addr(0, SUB_CLAIM), 32'hFFFF_FFFF); // source number out of range
    word_write(ctx_addr(1, SUB_CLAIM), 32'd5);    // not enabled there: no effect
    word_read(ctx_addr(HARTS, SUB_CLAIM));
    word_read(ctx_addr(0, 10'd2));                // past the claim word
    send_beat(REQ_READ, '0, {PEND_WORD, 2'b00}, WID_BYTE, '0);
    send_beat(REQ_WRITE, '0, enable_addr(1), WID_HALF, 32'hFFFF_FFFF);
    send_beat(REQ_READ, '0, ctx_addr(0, SUB_CLAIM), WID_ILLEGAL, '0);
    send_beat(REQ_NONE, 32'hFFFF_FFFF, 26'h3FF_FFFF, WID_ILLEGAL, 32'hFFFF_FFFF);
    send_beat(REQ_UPDATE, 32'h8000_0001, 26'h3FF_FFFF, WID_ILLEGAL, 32'hFFFF_FFFF);
  endtask

  // Well-formed traffic: updates, claims, and completion of what was claimed,
  // so sources cycle through pending -> claimed -> completed -> pending again.
  task automatic test_claim_complete_flow(input int unsigned rounds);
    int unsigned c;
    int unsigned n_claims;
    logic [31:0] src;
    logic [31:0] act;
    for (int c0 = 0; c0 < HARTS; c0++) word_write(enable_addr(c0), $urandom);
    for (int unsigned r = 0; r < rounds; r++) begin
      if ($urandom_range(0, 4) == 0) begin
        c = $urandom_range(0, HARTS - 1);
        word_write(enable_addr(c), ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom);
      end
      case ($urandom_range(0, 3))
        0: act = 32'd1 << $urandom_range(0, 31);
        1: act = $urandom & $urandom;
        2: act = '0;
        default: act = $urandom;
      endcase
      source_update(act);
      n_claims = $urandom_range(1, 3);
      for (int unsigned k = 0; k < n_claims; k++) begin
        c = $urandom_range(0, HARTS - 1);
        word_read(ctx_addr(c, SUB_CLAIM));
        src = last_reply.rdata;
        case ($urandom_range(0, 7))
          0: word_write(ctx_addr($urandom_range(0, HARTS - 1), SUB_CLAIM), src);
          1: word_read({PEND_WORD, 2'b00});
          2: word_read(enable_addr(c));
          default: word_write(ctx_addr(c, SUB_CLAIM), src);
        endcase
      end
    end
  endtask

  // Anything goes: every request and width code, addresses all over the map.
  task automatic test_random_noise(input int unsigned count);
    logic [25:0] addr;
    logic [31:0] wd;
    for (int unsigned i = 0; i < count; i++) begin
      case ($urandom_range(0, 6))
        0: addr = 26'($urandom);
        1: addr = {24'($urandom_range(0, 40)), 2'($urandom)};
        2: addr = {PEND_WORD, 2'($urandom)};
        3: addr = enable_addr($urandom_range(0, HARTS + 1)) + 26'($urandom_range(0, 7) * 4);
        4: addr = ctx_addr($urandom_range(0, HARTS + 1), 10'($urandom_range(0, 3)));
        5: addr = 26'h3FF_FFFF - 26'($urandom_range(0, 7));
        default: addr = ctx_addr($urandom_range(0, HARTS - 1), SUB_CLAIM);
      endcase
      wd = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 40)) : $urandom;
      send_beat(req_t'($urandom_range(0, 3)), $urandom, addr,
                width_t'(($urandom_range(0, 2) == 0) ? $urandom_range(0, 3) : WID_WORD), wd);
    end
  endtask

  // Result side holds off for a long stretch while beats keep coming, so both
  // internal registers fill and in_ready has to drop.
  task automatic test_output_backpressure(input int unsigned count);
    hold_asks <= hold_asks + 1;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 3 == 0) source_update($urandom);
      else word_read(ctx_addr($urandom_range(0, HARTS - 1), SUB_CLAIM));
    end
    while (hold_served != hold_asks || hold_left != 0) @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_register_map();
    test_claim_complete_flow(40);
    test_output_backpressure(40);
    test_random_noise(150);
    test_claim_complete_flow(40);
    test_output_backpressure(20);

    in_valid <= 1'b0;
    while (resp_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);   // room for a stray extra result beat
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
